// ===== hdl/eul_pkg.sv =====
// Package for the Euler angle to rotation matrix block.
// Holds formats, payload structs, constant tables and rounding helpers.
// No dependencies.
package eul_pkg;

  localparam int MATRIX_FRAC_BITS = 14;
  localparam int CORDIC_STAGES    = 16;
  localparam int HALF_TURN_DEG    = 180;
  localparam int UNITS_PER_DEG    = 64;
  localparam int FULL_TURN        = 2 * HALF_TURN_DEG * UNITS_PER_DEG;
  localparam int QUARTER_TURN     = FULL_TURN / 4;
  localparam int CORDIC_FRAC      = 30;
  localparam int CORDIC_GAIN_INV  = 652032874;
  localparam int ATAN_LEN         = 32;
  localparam int NSTAGE = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  localparam int FIELD_W = 16;
  localparam int ANG_W   = 16;
  localparam int R_W     = $clog2(FULL_TURN);
  localparam int T_W     = $clog2(QUARTER_TURN);
  localparam int SC_W    = MATRIX_FRAC_BITS + 2;
  localparam int PR_W    = SC_W + 2;
  localparam int CW      = CORDIC_FRAC + 3;

  // The full turn is an odd factor times a power of two; the binary angle
  // is formed as quotient and remainder by the odd factor.
  localparam int Z_POW    = 9;
  localparam int Z_ODD    = FULL_TURN >> Z_POW;
  localparam int Z_SCALE  = 32 - Z_POW;
  localparam int Z_HALF   = (FULL_TURN / 2) >> Z_POW;
  localparam int ZREC_SH  = 19;
  localparam int ZREC     = ((1 << ZREC_SH) + Z_ODD - 1) / Z_ODD;
  localparam int ZREC_W   = $clog2(ZREC + 1);
  localparam int Q1_W     = T_W + ZREC_W - ZREC_SH;
  localparam int REM_W    = $clog2(Z_ODD);

  localparam int NARROW_SH = CORDIC_FRAC - MATRIX_FRAC_BITS;
  localparam longint NARROW_HALF = (NARROW_SH == 0) ? 0 : (64'sd1 <<< (NARROW_SH - 1));
  localparam longint ONE = 64'sd1 <<< MATRIX_FRAC_BITS;

  typedef struct packed {
    logic signed [ANG_W-1:0] pitch_deg;
    logic signed [ANG_W-1:0] yaw_deg;
    logic signed [ANG_W-1:0] roll_deg;
  } eul_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m0x;
    logic signed [FIELD_W-1:0] m0y;
    logic signed [FIELD_W-1:0] m0z;
    logic signed [FIELD_W-1:0] m1x;
    logic signed [FIELD_W-1:0] m1y;
    logic signed [FIELD_W-1:0] m1z;
    logic signed [FIELD_W-1:0] m2x;
    logic signed [FIELD_W-1:0] m2y;
    logic signed [FIELD_W-1:0] m2z;
  } eul_out_t;

  typedef struct packed {
    logic signed [SC_W-1:0] s;
    logic signed [SC_W-1:0] c;
  } eul_sc_t;

  localparam logic [31:0] ATAN_TBL [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef logic [Z_SCALE-1:0] zfrac_tbl_t [Z_ODD];

  function automatic zfrac_tbl_t build_zfrac();
    zfrac_tbl_t tbl;
    longint v;
    for (int k = 0; k < Z_ODD; k++) begin
      v = ((longint'(k) <<< Z_SCALE) + Z_HALF) / Z_ODD;
      tbl[k] = v[Z_SCALE-1:0];
    end
    return tbl;
  endfunction

  localparam zfrac_tbl_t ZFRAC_TBL = build_zfrac();

  function automatic logic signed [PR_W-1:0] mul_round(input logic signed [PR_W-1:0] a,
                                                      input logic signed [PR_W-1:0] b);
    logic signed [2*PR_W-1:0] p;
    p = a * b + (2*PR_W)'(ONE >>> 1);
    p = p >>> MATRIX_FRAC_BITS;
    return p[PR_W-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] pack_entry(input logic signed [PR_W-1:0] v);
    logic signed [PR_W-1:0] c;
    if (v > PR_W'(ONE)) c = PR_W'(ONE);
    else if (v < -PR_W'(ONE)) c = -PR_W'(ONE);
    else c = v;
    return c[FIELD_W-1:0];
  endfunction

endpackage

// ===== hdl/eul_cordic_lane.sv =====
// One sine and cosine lane: angle reduction, pipelined CORDIC and quadrant fix.
// Depends on eul_pkg.
module eul_cordic_lane import eul_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] angle,
  output eul_sc_t                 sc
);

  // Reduction stage.
  logic signed [ANG_W:0] ax;
  logic signed [ANG_W:0] rs;
  logic [R_W-1:0]        r;
  logic [1:0]            q_nxt;
  logic [T_W-1:0]        t_nxt;
  logic [1:0]            q_a_r;
  logic [T_W-1:0]        t_a_r;

  always_comb begin
    ax = (ANG_W+1)'(angle);
    if (ax >= (ANG_W+1)'(FULL_TURN)) rs = ax - (ANG_W+1)'(FULL_TURN);
    else if (ax >= 0) rs = ax;
    else if (ax >= -(ANG_W+1)'(FULL_TURN)) rs = ax + (ANG_W+1)'(FULL_TURN);
    else rs = ax + (ANG_W+1)'(2 * FULL_TURN);
    r = rs[R_W-1:0];
    if (r >= R_W'(3 * QUARTER_TURN)) begin
      q_nxt = 2'd3;
      t_nxt = T_W'(r - R_W'(3 * QUARTER_TURN));
    end else if (r >= R_W'(2 * QUARTER_TURN)) begin
      q_nxt = 2'd2;
      t_nxt = T_W'(r - R_W'(2 * QUARTER_TURN));
    end else if (r >= R_W'(QUARTER_TURN)) begin
      q_nxt = 2'd1;
      t_nxt = T_W'(r - R_W'(QUARTER_TURN));
    end else begin
      q_nxt = 2'd0;
      t_nxt = T_W'(r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_a_r <= q_nxt;
      t_a_r <= t_nxt;
    end
  end

  // Binary angle stage: quotient by reciprocal, remainder through a table.
  logic [T_W+ZREC_W-1:0] qprod;
  logic [Q1_W-1:0]       q1;
  logic [T_W-1:0]        rem_full;
  logic signed [CW-1:0]  z_nxt;
  logic signed [CW-1:0]  z_b_r;
  logic [1:0]            q_b_r;

  always_comb begin
    qprod    = t_a_r * ZREC_W'(ZREC);
    q1       = qprod[T_W+ZREC_W-1:ZREC_SH];
    rem_full = t_a_r - T_W'(q1 * T_W'(Z_ODD));
    z_nxt    = (CW'(q1) <<< Z_SCALE) + CW'(ZFRAC_TBL[rem_full[REM_W-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_b_r <= z_nxt;
      q_b_r <= q_a_r;
    end
  end

  // CORDIC stages, one rotation per register.
  logic signed [CW-1:0] xs [NSTAGE+1];
  logic signed [CW-1:0] ys [NSTAGE+1];
  logic signed [CW-1:0] zs [NSTAGE+1];
  logic [1:0]           qs [NSTAGE+1];
  logic signed [CW-1:0] x_r [NSTAGE];
  logic signed [CW-1:0] y_r [NSTAGE];
  logic signed [CW-1:0] z_r [NSTAGE];
  logic [1:0]           q_r [NSTAGE];

  assign xs[0] = CW'(CORDIC_GAIN_INV);
  assign ys[0] = '0;
  assign zs[0] = z_b_r;
  assign qs[0] = q_b_r;

  for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          x_r[i] <= xs[i] - (ys[i] >>> i);
          y_r[i] <= ys[i] + (xs[i] >>> i);
          z_r[i] <= zs[i] - CW'(ATAN_TBL[i]);
        end else begin
          x_r[i] <= xs[i] + (ys[i] >>> i);
          y_r[i] <= ys[i] - (xs[i] >>> i);
          z_r[i] <= zs[i] + CW'(ATAN_TBL[i]);
        end
        q_r[i] <= qs[i];
      end
    end
    assign xs[i+1] = x_r[i];
    assign ys[i+1] = y_r[i];
    assign zs[i+1] = z_r[i];
    assign qs[i+1] = q_r[i];
  end

  // Narrowing and quadrant selection.
  function automatic logic signed [SC_W-1:0] narrow(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] w;
    w = (v + CW'(NARROW_HALF)) >>> NARROW_SH;
    if (w > CW'(ONE)) w = CW'(ONE);
    else if (w < -CW'(ONE)) w = -CW'(ONE);
    return w[SC_W-1:0];
  endfunction

  logic signed [SC_W-1:0] c_n;
  logic signed [SC_W-1:0] s_n;
  eul_sc_t                sc_nxt;
  eul_sc_t                sc_r;

  always_comb begin
    c_n = narrow(xs[NSTAGE]);
    s_n = narrow(ys[NSTAGE]);
    case (qs[NSTAGE])
      2'd0: begin
        sc_nxt.c = c_n;
        sc_nxt.s = s_n;
      end
      2'd1: begin
        sc_nxt.c = -s_n;
        sc_nxt.s = c_n;
      end
      2'd2: begin
        sc_nxt.c = -c_n;
        sc_nxt.s = -s_n;
      end
      default: begin
        sc_nxt.c = s_n;
        sc_nxt.s = -c_n;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r <= sc_nxt;
    end
  end

  assign sc = sc_r;

endmodule

// ===== hdl/eul_matrix_merge.sv =====
// Merging stage: combines the three lanes' sines and cosines into the matrix.
// Depends on eul_pkg. One registered product stage, then the final combination.
module eul_matrix_merge import eul_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  eul_sc_t  sc_p,
  input  eul_sc_t  sc_y,
  input  eul_sc_t  sc_rl,
  output eul_out_t mat
);

  logic signed [PR_W-1:0] sp, cp, sy, cy, sr, cr;
  assign sp = PR_W'(sc_p.s);
  assign cp = PR_W'(sc_p.c);
  assign sy = PR_W'(sc_y.s);
  assign cy = PR_W'(sc_y.c);
  assign sr = PR_W'(sc_rl.s);
  assign cr = PR_W'(sc_rl.c);

  logic signed [PR_W-1:0] srsp_r, crsp_r, cpcy_r, cpsy_r, crsy_r, crcy_r;
  logic signed [PR_W-1:0] srcp_r, srsy_r, srcy_r, crcp_r, sp_r, sy_r, cy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      srsp_r <= mul_round(sr, sp);
      crsp_r <= mul_round(cr, sp);
      cpcy_r <= mul_round(cp, cy);
      cpsy_r <= mul_round(cp, sy);
      crsy_r <= mul_round(cr, sy);
      crcy_r <= mul_round(cr, cy);
      srcp_r <= mul_round(sr, cp);
      srsy_r <= mul_round(sr, sy);
      srcy_r <= mul_round(sr, cy);
      crcp_r <= mul_round(cr, cp);
      sp_r   <= sp;
      sy_r   <= sy;
      cy_r   <= cy;
    end
  end

  always_comb begin
    mat.m0x = pack_entry(cpcy_r);
    mat.m0y = pack_entry(cpsy_r);
    mat.m0z = pack_entry(-sp_r);
    mat.m1x = pack_entry(mul_round(srsp_r, cy_r) - crsy_r);
    mat.m1y = pack_entry(mul_round(srsp_r, sy_r) + crcy_r);
    mat.m1z = pack_entry(srcp_r);
    mat.m2x = pack_entry(mul_round(crsp_r, cy_r) - srsy_r);
    mat.m2y = pack_entry(mul_round(crsp_r, sy_r) - srcy_r);
    mat.m2z = pack_entry(crcp_r);
  end

endmodule

// ===== hdl/euler_angles_to_rotation_matrix.sv =====
// Top level of the Euler angle to rotation matrix block.
// Depends on eul_pkg, eul_cordic_lane and eul_matrix_merge.
//
// The block takes one pitch, yaw and roll triple per transfer, each angle in
// signed degrees with 64 units per degree, and returns the nine entries of the
// rotation matrix in Q1.14, each saturated to plus or minus one. It accepts one
// triple every clock cycle while in_stall is low. Each result passes through the
// CORDIC pipeline of the three angle lanes (one register per rotation), with two
// stages of angle reduction ahead of it, one narrowing stage, one product stage
// in the merge and the output register; the first of these registers is loaded
// at the input transfer edge itself. The whole pipeline advances together; when
// a result waits on a stalled output, the input is stalled as well, and no
// transfer is lost or repeated.
module euler_angles_to_rotation_matrix import eul_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  eul_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output eul_out_t out_data
);

  // Stages from input to the merge output: reduction (2), CORDIC, narrowing,
  // merge products.
  localparam int LAT = NSTAGE + 4;

  logic     en;
  logic     vld_r [LAT];
  logic     out_valid_r;
  eul_out_t out_data_r;
  eul_sc_t  sc_p, sc_y, sc_rl;
  eul_out_t mat;

  // The pipeline moves whenever the output register is empty or being drained.
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  eul_cordic_lane u_lane_p (.clk(clk), .en(en), .angle(in_data.pitch_deg), .sc(sc_p));
  eul_cordic_lane u_lane_y (.clk(clk), .en(en), .angle(in_data.yaw_deg),   .sc(sc_y));
  eul_cordic_lane u_lane_r (.clk(clk), .en(en), .angle(in_data.roll_deg),  .sc(sc_rl));

  eul_matrix_merge u_merge (
    .clk   (clk),
    .en    (en),
    .sc_p  (sc_p),
    .sc_y  (sc_y),
    .sc_rl (sc_rl),
    .mat   (mat)
  );

  // Valid bits travel alongside the data in the lanes and the merge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= mat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_stall_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output register state");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result was dropped");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.m0z) <= 16384 && $signed(out_data.m0z) >= -16384 &&
                   $signed(out_data.m1y) <= 16384 && $signed(out_data.m1y) >= -16384 &&
                   $signed(out_data.m2x) <= 16384 && $signed(out_data.m2x) >= -16384))
    else $error("matrix entry out of saturation range");
`endif

endmodule

// ===== tb/sv/eul_matrix_checker.sv =====
// Checker for the Euler angle to rotation matrix block: predicts each matrix
// from the accepted angle triples and compares it with the accepted results.
// Depends on eul_pkg.
module eul_matrix_checker import eul_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  eul_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  eul_out_t out_data,
  output int       fail_count,
  output int       pending,
  output int       matrix_count
);
  timeunit 1ns;
  timeprecision 1ps;

  eul_out_t expected_matrices[$];

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    longint one;
    one = longint'(1) <<< MATRIX_FRAC_BITS;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return floor_shift(a * b + (longint'(1) <<< (MATRIX_FRAC_BITS - 1)), MATRIX_FRAC_BITS);
  endfunction

  // Sine and cosine of one angle: reduce to a quadrant and a residual, rotate
  // the residual by CORDIC and let the quadrant fix signs and order.
  task automatic angle_sin_cos(input logic signed [15:0] ang, output longint sn,
                               output longint cs);
    longint r, q, t, z, x, y, nx, s, c;
    int sh;
    r = longint'(ang) % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    q = r / QUARTER_TURN;
    t = r - q * QUARTER_TURN;
    z = ((t <<< 32) + FULL_TURN / 2) / FULL_TURN;
    x = CORDIC_GAIN_INV;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= longint'(ATAN_TBL[i]);
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += longint'(ATAN_TBL[i]);
      end
      x = nx;
    end
    sh = CORDIC_FRAC - MATRIX_FRAC_BITS;
    c = clamp_unit(floor_shift(x + (longint'(1) <<< (sh - 1)), sh));
    s = clamp_unit(floor_shift(y + (longint'(1) <<< (sh - 1)), sh));
    case (q)
      0: begin cs = c; sn = s; end
      1: begin cs = -s; sn = c; end
      2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endtask

  function automatic logic [15:0] entry(longint v);
    longint c;
    c = clamp_unit(v);
    return c[15:0];
  endfunction

  task automatic predict_matrix(input eul_in_t a, output eul_out_t m);
    longint sp, cp, sy, cy, sr, cr, srsp, crsp;
    angle_sin_cos(a.pitch_deg, sp, cp);
    angle_sin_cos(a.yaw_deg, sy, cy);
    angle_sin_cos(a.roll_deg, sr, cr);
    srsp = q_mul(sr, sp);
    crsp = q_mul(cr, sp);
    m.m0x = entry(q_mul(cp, cy));
    m.m0y = entry(q_mul(cp, sy));
    m.m0z = entry(-sp);
    m.m1x = entry(q_mul(srsp, cy) - q_mul(cr, sy));
    m.m1y = entry(q_mul(srsp, sy) + q_mul(cr, cy));
    m.m1z = entry(q_mul(sr, cp));
    m.m2x = entry(q_mul(crsp, cy) - q_mul(sr, sy));
    m.m2y = entry(q_mul(crsp, sy) - q_mul(sr, cy));
    m.m2z = entry(q_mul(cr, cp));
  endtask

  task automatic compare_field(string name, logic signed [15:0] exp_v,
                               logic signed [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Counters and the queue of expected matrices are cleared while in reset.
  always @(posedge clk) begin
    eul_out_t m, e;
    if (!rst_n) begin
      fail_count = 0;
      matrix_count = 0;
      expected_matrices.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_matrix(in_data, m);
        expected_matrices = {expected_matrices, m};
      end
      if (out_valid && !out_stall) begin
        matrix_count++;
        if (expected_matrices.size() == 0) begin
          $error("matrix result with no angle triple outstanding");
          fail_count++;
        end else begin
          e = expected_matrices.pop_front();
          compare_field("m0x", e.m0x, out_data.m0x);
          compare_field("m0y", e.m0y, out_data.m0y);
          compare_field("m0z", e.m0z, out_data.m0z);
          compare_field("m1x", e.m1x, out_data.m1x);
          compare_field("m1y", e.m1y, out_data.m1y);
          compare_field("m1z", e.m1z, out_data.m1z);
          compare_field("m2x", e.m2x, out_data.m2x);
          compare_field("m2y", e.m2y, out_data.m2y);
          compare_field("m2z", e.m2z, out_data.m2z);
        end
      end
    end
    pending = expected_matrices.size();
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the testbench for the Euler angle to rotation matrix block.
// Depends on eul_pkg, the block itself and eul_matrix_checker.
module tb_top;
  import eul_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  eul_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  eul_out_t out_data;
  int       fail_count;
  int       pending;
  int       matrix_count;

  // Once this is set, neither side idles any more.
  logic     calm_phase;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  euler_angles_to_rotation_matrix u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  eul_matrix_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending), .matrix_count(matrix_count)
  );

  // The output side stalls in bursts of random length, separated by runs of free
  // cycles, and stops stalling altogether in the calm phase.
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Presents one angle triple and holds it until the transfer happens, which
  // is seen at the rising edge; the payload then changes at the falling edge.
  task automatic send_angles(input logic [15:0] p, input logic [15:0] y,
                             input logic [15:0] r);
    int gap;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.pitch_deg <= p;
    in_data.yaw_deg   <= y;
    in_data.roll_deg  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random angle: mostly across the full range, with some weight on quadrant
  // boundaries and whole turns, where the sign and order logic switches.
  function automatic logic [15:0] pick_angle();
    int k;
    case ($urandom_range(0, 3))
      0: begin
        k = $urandom_range(0, 22) - 11;
        return 16'(k * QUARTER_TURN + $urandom_range(0, 2) - 1);
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int wait_cycles;
    logic [15:0] extremes[8];
    calm_phase = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: field extremes, zero, quadrant edges and exact half
    // turns, so that every quadrant and the saturation limits are reached.
    extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                 16'(QUARTER_TURN), 16'(-QUARTER_TURN), 16'(2 * QUARTER_TURN),
                 16'(3 * QUARTER_TURN - 1)};
    foreach (extremes[i]) send_angles(extremes[i], extremes[i], extremes[i]);
    send_angles(16'h0000, 16'h7FFF, 16'h8000);
    send_angles(16'h8000, 16'h0000, 16'h7FFF);
    send_angles(16'h7FFF, 16'h8000, 16'h0000);
    send_angles(16'(FULL_TURN), 16'(-FULL_TURN), 16'h0001);
    send_angles(16'(QUARTER_TURN / 2), 16'(3 * QUARTER_TURN / 2), 16'(-QUARTER_TURN / 2));
    send_angles(16'h5555, 16'hAAAA, 16'h5555);
    send_angles(16'hAAAA, 16'h5555, 16'hAAAA);

    for (int n = 0; n < 1600; n++) begin
      if (n == 1400) calm_phase = 1'b1;
      send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected matrix, then allow the pipeline depth.
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (CORDIC_STAGES + 10) @(posedge clk);

    $display("Checked %0d rotation matrices, covering all quadrants of each angle,",
             matrix_count);
    $display("the limits of every angle field and random idling on both sides.");
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending != 0) $error("%0d expected matrices never arrived", pending);
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/eul_pkg.sv
hdl/eul_cordic_lane.sv
hdl/eul_matrix_merge.sv
hdl/euler_angles_to_rotation_matrix.sv
tb/sv/eul_matrix_checker.sv
tb/sv/tb_top.sv
